// ===== hdl/glp_pkg.sv =====
// glp_pkg: shared constants, codes and types of the greedy line packer
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package glp_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 64;
   localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

   // field widths
   localparam int FUNC_W = 2;
   localparam int DIM_W  = 16;
   localparam int TOT_W  = 17;
   localparam int SLOT_W = 6;
   localparam int Y_W    = 32;

   // register port
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;
   localparam logic       REG_LINE_WIDTH = 1'b0;
   localparam logic [DIM_W-1:0] LINE_WIDTH_RST = 16'hFFFF;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BREAK = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PAGE  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FLUSH = 2'b10
   } seq_state_type;

   // access to the width store
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [DIM_W-1:0] wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== hdl/glp_if.sv =====
// glp_if: valid/ready channel interfaces for box items and placement results
// depends on glp_pkg for field widths
`default_nettype none

interface glp_req_if
   import glp_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DIM_W-1:0]  box_width;
   logic [DIM_W-1:0]  box_height;
   logic [DIM_W-1:0]  box_baseline;

   modport source (output valid, func, box_width, box_height, box_baseline,
                   input ready);
   modport sink   (input valid, func, box_width, box_height, box_baseline,
                   output ready);
endinterface

interface glp_rsp_if
   import glp_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [SLOT_W-1:0]     slot;
   logic [DIM_W-1:0]      x_offset;
   logic signed [Y_W-1:0] line_y;
   logic [DIM_W-1:0]      line_baseline;
   logic                  last;

   modport source (output valid, slot, x_offset, line_y, line_baseline, last,
                   input ready);
   modport sink   (input valid, slot, x_offset, line_y, line_baseline, last,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/glp_csr.sv =====
// glp_csr: apb-style register block holding the available line width
// depends on glp_pkg
`default_nettype none

module glp_csr
   import glp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      logic [DIM_W-1:0]      line_width
);

   logic [DIM_W-1:0] line_width_ff;
   logic [DIM_W-1:0] line_width_in;
   logic             wr_hit;

   // register index sits above the word offset
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);

   always_comb begin
      line_width_in = line_width_ff;
      if (wr_hit) begin
         line_width_in = pwdata[DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RST;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_LINE_WIDTH) begin
         prdata = APB_DATA_W'(line_width_ff);
      end
   end

   assign pready     = 1'b1;
   assign line_width = line_width_ff;

endmodule

`default_nettype wire

// ===== hdl/glp_line_mem.sv =====
// glp_line_mem: width store of the pending line, one write and one read port
// depends on glp_pkg; read data is registered
`default_nettype none

module glp_line_mem
   import glp_pkg::*;
(
   input  wire logic             clock,
   input  wire mem_req_type      mem_req,
   output      logic [DIM_W-1:0] rd_data
);

   logic [DIM_W-1:0] mem [LINE_DEPTH];
   logic [DIM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/glp_seq.sv =====
// glp_seq: line state, flush sequencer and result register of the packer
// depends on glp_pkg and the glp_req_if / glp_rsp_if interfaces
`default_nettype none

module glp_seq
   import glp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   glp_req_if.sink               req_bus,
   glp_rsp_if.source             rsp_bus,
   input  wire logic [DIM_W-1:0] line_width,
   output      mem_req_type      mem_req,
   input  wire logic [DIM_W-1:0] rd_data
);

   seq_state_type         state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TOT_W-1:0]      total_ff, total_in;
   logic [DIM_W-1:0]      max_h_ff, max_h_in;
   logic [DIM_W-1:0]      max_b_ff, max_b_in;
   logic signed [Y_W-1:0] y_ff, y_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [TOT_W-1:0]      x_ff, x_in;
   logic                  held_ff, held_in;
   logic [DIM_W-1:0]      hw_ff, hw_in;
   logic [DIM_W-1:0]      hh_ff, hh_in;
   logic [DIM_W-1:0]      hb_ff, hb_in;

   logic                  rv_ff, rv_in;
   logic [SLOT_W-1:0]     rslot_ff, rslot_in;
   logic [DIM_W-1:0]      rx_ff, rx_in;
   logic signed [Y_W-1:0] ry_ff, ry_in;
   logic [DIM_W-1:0]      rb_ff, rb_in;
   logic                  rlast_ff, rlast_in;

   logic                  accept;
   logic                  load_ok;
   logic [CNT_W-1:0]      cnt_dec;
   logic [TOT_W:0]        fit_sum;
   logic                  no_fit;
   logic [TOT_W-1:0]      x_sub;
   logic [Y_W:0]          y_drop;
   logic signed [Y_W-1:0] y_sat;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_ok       = !rv_ff || rsp_bus.ready;
   assign cnt_dec       = count_ff - CNT_W'(1);
   assign fit_sum       = {1'b0, total_ff} + (TOT_W + 1)'(req_bus.box_width);
   assign no_fit        = (fit_sum > (TOT_W + 1)'(line_width))
                          || (count_ff == CNT_W'(LINE_DEPTH));
   assign x_sub         = x_ff - TOT_W'(rd_data);

   // y drops by the tallest box, saturating at the most negative value
   assign y_drop = {y_ff[Y_W-1], y_ff} - (Y_W + 1)'(max_h_ff);
   assign y_sat  = (y_drop[Y_W] != y_drop[Y_W-1]) ? {1'b1, {(Y_W-1){1'b0}}}
                                                   : y_drop[Y_W-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      max_h_in = max_h_ff;
      max_b_in = max_b_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      held_in  = held_ff;
      hw_in    = hw_ff;
      hh_in    = hh_ff;
      hb_in    = hb_ff;
      rv_in    = rv_ff && !rsp_bus.ready;
      rslot_in = rslot_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rb_in    = rb_ff;
      rlast_in = rlast_ff;
      mem_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.func)
                  FUNC_PUSH: begin
                     if ((count_ff != '0) && no_fit) begin
                        // flush first, box is applied when the line is out
                        state_in        = ST_FLUSH;
                        k_in            = cnt_dec[IDX_W-1:0];
                        x_in            = total_ff;
                        held_in         = 1'b1;
                        hw_in           = req_bus.box_width;
                        hh_in           = req_bus.box_height;
                        hb_in           = req_bus.box_baseline;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cnt_dec[IDX_W-1:0];
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[IDX_W-1:0];
                        mem_req.wr_data = req_bus.box_width;
                        count_in        = count_ff + CNT_W'(1);
                        total_in        = fit_sum[TOT_W-1:0];
                        if (req_bus.box_height > max_h_ff) begin
                           max_h_in = req_bus.box_height;
                        end
                        if (req_bus.box_baseline > max_b_ff) begin
                           max_b_in = req_bus.box_baseline;
                        end
                     end
                  end
                  FUNC_BREAK: begin
                     if (count_ff != '0) begin
                        state_in        = ST_FLUSH;
                        k_in            = cnt_dec[IDX_W-1:0];
                        x_in            = total_ff;
                        held_in         = 1'b0;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cnt_dec[IDX_W-1:0];
                     end
                  end
                  FUNC_PAGE: begin
                     count_in = '0;
                     total_in = '0;
                     max_h_in = '0;
                     max_b_in = '0;
                     y_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            if (load_ok) begin
               rv_in    = 1'b1;
               rslot_in = SLOT_W'(k_ff);
               rx_in    = x_sub[DIM_W-1:0];
               ry_in    = y_ff;
               rb_in    = max_b_ff;
               rlast_in = (k_ff == '0);
               x_in     = x_sub;
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
                  y_in     = y_sat;
                  if (held_ff) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = '0;
                     mem_req.wr_data = hw_ff;
                     count_in        = CNT_W'(1);
                     total_in        = TOT_W'(hw_ff);
                     max_h_in        = hh_ff;
                     max_b_in        = hb_ff;
                  end else begin
                     count_in = '0;
                     total_in = '0;
                     max_h_in = '0;
                     max_b_in = '0;
                  end
               end else begin
                  k_in            = k_ff - IDX_W'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = k_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         max_h_ff <= '0;
         max_b_ff <= '0;
         y_ff     <= '0;
         held_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         max_h_ff <= max_h_in;
         max_b_ff <= max_b_in;
         y_ff     <= y_in;
         held_ff  <= held_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      x_ff     <= x_in;
      hw_ff    <= hw_in;
      hh_ff    <= hh_in;
      hb_ff    <= hb_in;
      rslot_ff <= rslot_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rb_ff    <= rb_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_bus.valid         = rv_ff;
   assign rsp_bus.slot          = rslot_ff;
   assign rsp_bus.x_offset      = rx_ff;
   assign rsp_bus.line_y        = ry_ff;
   assign rsp_bus.line_baseline = rb_ff;
   assign rsp_bus.last          = rlast_ff;

endmodule

`default_nettype wire

// ===== hdl/greedy_line_packer.sv =====
// greedy_line_packer: top level of the greedy line packer
// depends on glp_pkg, glp_if, glp_csr, glp_line_mem and glp_seq
//
// Packs boxes into lines greedily. A push beat adds a box to the pending
// line; when the box does not fit in line_width (or the store already holds
// LINE_DEPTH boxes) the pending line is flushed first, then the box starts
// the next line. A break beat flushes, a page beat drops the pending line
// and brings y back to 0. A flush sends one result beat per box, last box
// first, each with its x offset, the line's top y and its largest baseline;
// afterwards y drops by the tallest box of the line and saturates at the
// most negative value. Push, page and break of an empty line are taken
// without a stall. A flush holds req ready low until its last result is
// loaded: the first read of the width store is launched in the accepting
// cycle, then one result per cycle while rsp takes them, paced by its
// single read port and its registered read data. Back-pressure on rsp
// stretches the flush beat for beat. The width store needs no clearing
// pass after reset.
// Register 0 (line_width) lies at byte address 0; write it only while idle.
`default_nettype none

module greedy_line_packer
   import glp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   glp_req_if.sink                    req_bus,
   glp_rsp_if.source                  rsp_bus,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [APB_ADDR_W-1:0] paddr,
   input  wire logic [APB_DATA_W-1:0] pwdata,
   output      logic [APB_DATA_W-1:0] prdata,
   output      logic                  pready
);

   // available width, from the register block
   logic [DIM_W-1:0] line_width;
   // width store access and its registered read data
   mem_req_type      mem_req;
   logic [DIM_W-1:0] rd_data;

   glp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .line_width (line_width)
   );

   // widths of the pending boxes, read back last to first during a flush
   glp_line_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // line state, flush sequencing and the result register
   glp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .line_width (line_width),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

endmodule

`default_nettype wire
